FILE: hdl/sphl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sphl_pkg
// Shared types and constants of the sparse packet header locator.
// ----------------------------------------------------------------------------
package sphl_pkg;

  localparam int STORE_BYTES = 4096;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int LEN_W       = ADDR_W + 1;
  localparam int BYTE_W      = 8;
  localparam int OFF_W       = 13;
  localparam int CFG_IDX_W   = 2;

  localparam logic [BYTE_W-1:0] PSIZE_RESET = 8'd188;
  localparam logic [BYTE_W-1:0] LEAD_RESET  = 8'd71;

  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_BYTE   = 2'd1;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    logic              last_byte;
  } in_req_t;

  typedef struct packed {
    logic [OFF_W-1:0] header_offset;
    logic             none_valid;
    logic             overflowed;
  } out_req_t;

  typedef struct packed {
    logic [LEN_W-1:0]  quot;
    logic [BYTE_W-1:0] rem;
  } div_res_t;

endpackage
`default_nettype wire

FILE: hdl/sphl_byte_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sphl_byte_ram
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sphl_byte_ram import sphl_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [BYTE_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem_q [STORE_BYTES];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: hdl/sphl_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sphl_div
// Restoring divider, one quotient bit per cycle: region length by packet size.
// ----------------------------------------------------------------------------
module sphl_div import sphl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [LEN_W-1:0]  dividend_i,
  input  logic [BYTE_W-1:0] divisor_i,
  output logic              done_o,
  output div_res_t          res_o
);

  localparam int CNT_W = $clog2(LEN_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0]  num_q, num_d;
  logic [BYTE_W-1:0] rem_q, rem_d;
  logic [BYTE_W-1:0] dsor_q, dsor_d;
  logic [BYTE_W:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    dsor_d = dsor_q;
    trial  = {rem_q, num_q[LEN_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(LEN_W);
      num_d  = dividend_i;
      rem_d  = '0;
      dsor_d = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsor_q}) begin
        rem_d = BYTE_W'(trial - {1'b0, dsor_q});
        num_d = {num_q[LEN_W-2:0], 1'b1};
      end else begin
        rem_d = trial[BYTE_W-1:0];
        num_d = {num_q[LEN_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    dsor_q <= dsor_d;
  end

  assign done_o     = done_q;
  assign res_o.quot = num_q;
  assign res_o.rem  = rem_q;

endmodule
`default_nettype wire

FILE: hdl/sparse_packet_header_locator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_packet_header_locator_top
// Stores a region byte by byte, then binary searches packet heads for the
// first one that carries the lead byte.
//
//   channel | direction | handshake             | payload
//   in      | request   | in_valid/in_ready     | in_req_i  (byte, last flag)
//   out     | result    | out_valid/out_ready   | out_req_o (offset, flags)
//   cfg     | write     | cfg_valid/cfg_ready   | cfg_index_i, cfg_data_i
//
// Bytes load at one per cycle into the byte store while no search runs.
// After the last byte the length is divided by the packet size (one quotient
// bit per cycle); each probe then passes address, read and compare states,
// up to about 2 + log2(length / packet size) probes, plus a final offset step.
// The result sits in an output register; loading resumes once it is taken in.
// Reset clears control state only; the store needs no clearing.
// ----------------------------------------------------------------------------
module sparse_packet_header_locator_top import sphl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_req_t              in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_req_t             out_req_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BYTE_W-1:0]    cfg_data_i
);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_ADDR = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_END  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  localparam logic [1:0] K_FIRST = 2'd0;
  localparam logic [1:0] K_LAST  = 2'd1;
  localparam logic [1:0] K_MID   = 2'd2;
  localparam logic [1:0] K_END   = 2'd3;

  logic [2:0]        state_q, state_d;
  logic [1:0]        kind_q, kind_d;
  logic [LEN_W-1:0]  fill_q, fill_d;
  logic              ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] psize_q, lead_q;

  logic [LEN_W-1:0]  len_q, len_d;
  logic [BYTE_W-1:0] phase_q, phase_d;
  logic [LEN_W-1:0]  count_q, count_d;
  logic [LEN_W-1:0]  lo_q, lo_d;
  logic [LEN_W-1:0]  hi_q, hi_d;
  logic [LEN_W-1:0]  idx_q, idx_d;
  logic [LEN_W-1:0]  pos_q, pos_d;
  out_req_t          res_q, res_d;
  out_req_t          out_q, out_d;

  logic              in_acc;
  logic              store_full;
  logic [LEN_W-1:0]  len_nxt;
  logic [BYTE_W-1:0] psize_eff;
  logic              div_done;
  div_res_t          div_res;
  logic [BYTE_W-1:0] rdata;
  logic              hit;
  logic [LEN_W-1:0]  nlo, nhi, nmid;
  logic              more;
  logic [LEN_W+BYTE_W-1:0] prod;

  assign in_ready_o  = (state_q == S_LOAD);
  assign in_acc      = in_valid_i & in_ready_o;
  assign store_full  = (fill_q == LEN_W'(STORE_BYTES));
  assign len_nxt     = store_full ? fill_q : fill_q + 1'b1;
  assign psize_eff   = (psize_q == '0) ? BYTE_W'(1) : psize_q;
  assign hit         = (rdata == lead_q);
  assign prod        = (LEN_W+BYTE_W)'(idx_q) * (LEN_W+BYTE_W)'(psize_eff)
                     + (LEN_W+BYTE_W)'(phase_q);
  assign cfg_ready_o = 1'b1;

  sphl_byte_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc & ~store_full),
    .waddr_i (fill_q[ADDR_W-1:0]),
    .wdata_i (in_req_i.byte_value),
    .re_i    (state_q == S_RD),
    .raddr_i (pos_q[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  sphl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc & in_req_i.last_byte),
    .dividend_i (len_nxt),
    .divisor_i  (psize_eff),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  // next search window after a probe
  always_comb begin
    if (kind_q == K_LAST) begin
      nlo = '0;
      nhi = count_q - 1'b1;
    end else if (hit) begin
      nlo = lo_q;
      nhi = idx_q;
    end else begin
      nlo = idx_q;
      nhi = hi_q;
    end
    more = ((nlo + 1'b1) < nhi);
    nmid = nlo + ((nhi - nlo) >> 1);
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    len_d       = len_q;
    phase_d     = phase_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    res_d       = res_q;
    out_d       = out_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (store_full) begin
            ovf_d = 1'b1;
          end else begin
            fill_d = fill_q + 1'b1;
          end
          if (in_req_i.last_byte) begin
            len_d          = len_nxt;
            res_d.overflowed = ovf_q | store_full;
            fill_d         = '0;
            ovf_d          = 1'b0;
            state_d        = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          count_d = div_res.quot;
          phase_d = div_res.rem;
          if (div_res.quot == '0) begin
            res_d.header_offset = OFF_W'(len_q);
            res_d.none_valid    = 1'b1;
            state_d             = S_FIN;
          end else begin
            idx_d   = '0;
            kind_d  = K_FIRST;
            state_d = S_ADDR;
          end
        end
      end
      S_ADDR: begin
        pos_d   = LEN_W'(prod);
        state_d = (kind_q == K_END) ? S_END : S_RD;
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        case (kind_q)
          K_FIRST: begin
            if (hit) begin
              res_d.header_offset = OFF_W'(phase_q);
              res_d.none_valid    = 1'b0;
              state_d             = S_FIN;
            end else if (count_q == LEN_W'(1)) begin
              res_d.header_offset = OFF_W'(len_q);
              res_d.none_valid    = 1'b1;
              state_d             = S_FIN;
            end else begin
              idx_d   = count_q - 1'b1;
              kind_d  = K_LAST;
              state_d = S_ADDR;
            end
          end
          K_LAST, K_MID: begin
            if (kind_q == K_LAST && !hit) begin
              res_d.header_offset = OFF_W'(len_q);
              res_d.none_valid    = 1'b1;
              state_d             = S_FIN;
            end else begin
              lo_d    = nlo;
              hi_d    = nhi;
              idx_d   = more ? nmid : nhi;
              kind_d  = more ? K_MID : K_END;
              state_d = S_ADDR;
            end
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end
      S_END: begin
        res_d.header_offset = OFF_W'(pos_q);
        res_d.none_valid    = 1'b0;
        state_d             = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      kind_q      <= K_FIRST;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      psize_q     <= PSIZE_RESET;
      lead_q      <= LEAD_RESET;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_index_i == CFG_PACKET_SIZE) begin
        psize_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == CFG_LEAD_BYTE) begin
        lead_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q   <= len_d;
    phase_q <= phase_d;
    count_q <= count_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    idx_q   <= idx_d;
    pos_q   <= pos_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule
`default_nettype wire

FILE: hdl/sphl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sphl_checker
// Port-level checks of the header locator, bound to the top level.
// ----------------------------------------------------------------------------
module sphl_checker import sphl_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire in_req_t              in_req_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire out_req_t             out_req_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_req_o))
    else $error("result changed while stalled");

  // a found header lies inside the store
  a_off_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_req_o.none_valid |-> out_req_o.header_offset < OFF_W'(STORE_BYTES))
    else $error("header offset beyond store");

  // last byte starts the search, input closes
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_req_i.last_byte |=> !in_ready_o)
    else $error("input open during search");

  // with no result pending, none appears in the cycle after the last byte
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_req_i.last_byte && !out_valid_o |=> !out_valid_o)
    else $error("result before search");

endmodule

bind sparse_packet_header_locator_top sphl_checker u_sphl_checker (.*);
`default_nettype wire
